>>> hw/rtl/ddar_pkg.sv
// Shared constants, request codes and the default command type of the DDA line rasterizer.
package ddar_pkg;

   // Default coordinate width and the depth of the front-to-back command queue.
   localparam int COORD_BITS_DEF  = 12;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Fixed-point scale of the minor accumulator: a power of two, so that
   // taking the integer part is a plain bit select.
   localparam int FRAC_BITS  = 13;
   localparam int FRAC_SCALE = 1 << FRAC_BITS;

   localparam int COLOR_BITS = 24;

   // Request kinds carried in req_tuser.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   // Classified command at the default coordinate width. The top level
   // declares the same layout at its own coordinate width.
   typedef struct packed {
      logic                      mode;
      logic                      steep;
      logic                      major_down;
      logic                      minor_neg;
      logic [COORD_BITS_DEF-1:0] major_start;
      logic [COORD_BITS_DEF-1:0] major_end;
      logic [COORD_BITS_DEF-1:0] minor_start;
      logic [COORD_BITS_DEF-1:0] minor_mag;
      logic [COORD_BITS_DEF-1:0] major_mag;
      logic [COLOR_BITS-1:0]     color;
   } cmd_default_type;

endpackage

>>> hw/rtl/ddar_front.sv
// Front end: takes requests, picks the major axis and forms the command for the queue.
module ddar_front
   import ddar_pkg::*;
#(
   parameter int  COORD_BITS = COORD_BITS_DEF,
   parameter type cmd_type   = cmd_default_type
) (
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   // start_x, start_y, end_x, end_y, line_color (lowest bits first), zero filled
   input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0]      req_tdata,
   // mode
   input  logic                                              req_tuser,
   input  logic                                              queue_full,
   output logic                                              push_valid,
   output cmd_type                                           push_cmd
);

   logic [COORD_BITS-1:0]        start_x;
   logic [COORD_BITS-1:0]        start_y;
   logic [COORD_BITS-1:0]        end_x;
   logic [COORD_BITS-1:0]        end_y;
   logic [COLOR_BITS-1:0]        line_color;
   logic signed [COORD_BITS:0]   delta_x;
   logic signed [COORD_BITS:0]   delta_y;
   logic signed [COORD_BITS:0]   neg_x;
   logic signed [COORD_BITS:0]   neg_y;
   logic [COORD_BITS-1:0]        abs_x;
   logic [COORD_BITS-1:0]        abs_y;
   logic                         steep;

   // Field unpacking.
   assign start_x    = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign start_y    = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign end_x      = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign end_y      = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign line_color = req_tdata[4*COORD_BITS +: COLOR_BITS];

   // Signed deltas and their magnitudes.
   assign delta_x = signed'({1'b0, end_x}) - signed'({1'b0, start_x});
   assign delta_y = signed'({1'b0, end_y}) - signed'({1'b0, start_y});
   assign neg_x   = -delta_x;
   assign neg_y   = -delta_y;
   assign abs_x   = delta_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : delta_x[COORD_BITS-1:0];
   assign abs_y   = delta_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : delta_y[COORD_BITS-1:0];

   // Shallow lines walk x, everything else (ties included) walks y.
   assign steep = !(abs_x > abs_y);

   // Command formation; step requests carry the same fields unused.
   always_comb begin
      push_cmd.mode        = req_tuser;
      push_cmd.steep       = steep;
      push_cmd.major_start = steep ? start_y : start_x;
      push_cmd.major_end   = steep ? end_y : end_x;
      push_cmd.minor_start = steep ? start_x : start_y;
      push_cmd.minor_mag   = steep ? abs_x : abs_y;
      push_cmd.major_mag   = steep ? abs_y : abs_x;
      push_cmd.minor_neg   = steep ? delta_x[COORD_BITS] : delta_y[COORD_BITS];
      push_cmd.major_down  = steep ? (end_y < start_y) : (end_x < start_x);
      push_cmd.color       = line_color;
   end

   assign req_tready = !queue_full;
   assign push_valid = req_tvalid && !queue_full;

endmodule

>>> hw/rtl/ddar_queue.sv
// Small command queue that decouples the front end from the back end.
module ddar_queue
   import ddar_pkg::*;
#(
   parameter int  DEPTH    = QUEUE_DEPTH_DEF,
   parameter type cmd_type = cmd_default_type
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cmd_type               entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  do_pop;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hw/rtl/ddar_div.sv
// Restoring divider, one quotient bit per cycle, for the slope of a new line.
module ddar_div
   import ddar_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [COORD_BITS-1:0]            numer_mag,
   input  logic [COORD_BITS-1:0]            denom,
   output logic                             done,
   output logic [COORD_BITS+FRAC_BITS-1:0]  quotient
);

   localparam int DIV_BITS = COORD_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0]   dvd_ff;
   logic [DIV_BITS-1:0]   dvd_in;
   logic [DIV_BITS-1:0]   quo_ff;
   logic [DIV_BITS-1:0]   quo_in;
   logic [COORD_BITS-1:0] rem_ff;
   logic [COORD_BITS-1:0] rem_in;
   logic [COORD_BITS-1:0] den_ff;
   logic [COORD_BITS-1:0] den_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [CNT_BITS-1:0]   cnt_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  fits;

   // One step: bring down the next dividend bit and try the subtract.
   assign trial = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // The dividend is the minor magnitude scaled by the fraction.
         dvd_in  = {numer_mag, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_BITS-2:0], 1'b0};
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/ddar_back.sv
// Back end: runs queued commands, holds the line state and emits pixels.
module ddar_back
   import ddar_pkg::*;
#(
   parameter int  COORD_BITS = COORD_BITS_DEF,
   parameter type cmd_type   = cmd_default_type
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  cmd_type                head_cmd,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [COORD_BITS-1:0]  pixel_x,
   output logic [COORD_BITS-1:0]  pixel_y,
   output logic [COLOR_BITS-1:0]  pixel_color,
   output logic                   line_done,
   output logic                   pixel_last
);

   localparam int DIV_BITS = COORD_BITS + FRAC_BITS;
   localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_MAIN = 2'd2;

   logic [1:0]                  state_ff;
   logic [1:0]                  state_in;
   logic                        active_ff;
   logic                        active_in;
   logic                        steep_ff;
   logic                        steep_in;
   logic                        major_down_ff;
   logic                        major_down_in;
   logic                        slope_neg_ff;
   logic                        slope_neg_in;
   logic [COORD_BITS-1:0]       major_pos_ff;
   logic [COORD_BITS-1:0]       major_pos_in;
   logic [COORD_BITS-1:0]       major_end_ff;
   logic [COORD_BITS-1:0]       major_end_in;
   logic [COORD_BITS-1:0]       minor_pos_ff;
   logic [COORD_BITS-1:0]       minor_pos_in;
   logic [COORD_BITS-1:0]       minor_prev_ff;
   logic [COORD_BITS-1:0]       minor_prev_in;
   logic signed [ACC_BITS-1:0]  minor_acc_ff;
   logic signed [ACC_BITS-1:0]  minor_acc_in;
   logic signed [ACC_BITS-1:0]  minor_slope_ff;
   logic signed [ACC_BITS-1:0]  minor_slope_in;
   logic [COLOR_BITS-1:0]       held_color_ff;
   logic [COLOR_BITS-1:0]       held_color_in;

   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [COORD_BITS-1:0]       out_x_ff;
   logic [COORD_BITS-1:0]       out_x_in;
   logic [COORD_BITS-1:0]       out_y_ff;
   logic [COORD_BITS-1:0]       out_y_in;
   logic [COLOR_BITS-1:0]       out_color_ff;
   logic [COLOR_BITS-1:0]       out_color_in;
   logic                        out_done_ff;
   logic                        out_done_in;
   logic                        out_last_ff;
   logic                        out_last_in;

   logic                        out_free;
   logic                        main_fire;
   logic                        main_done;
   logic signed [ACC_BITS-1:0]  acc_sum;
   logic [COORD_BITS-1:0]       acc_whole;
   logic [COORD_BITS-1:0]       major_next;
   logic signed [ACC_BITS-1:0]  slope_mag;
   logic                        div_start;
   logic                        div_done;
   logic [DIV_BITS-1:0]         div_quo;

   // Slope divider: minor magnitude times the scale over the major magnitude.
   ddar_div #(
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numer_mag (head_cmd.minor_mag),
      .denom     (head_cmd.major_mag),
      .done      (div_done),
      .quotient  (div_quo)
   );

   assign slope_mag = signed'({{(ACC_BITS-DIV_BITS){1'b0}}, div_quo});

   // Next position along the line; a negative sum clamps to pixel zero.
   assign main_done  = (major_pos_ff == major_end_ff);
   assign acc_sum    = minor_acc_ff + minor_slope_ff;
   assign acc_whole  = acc_sum[ACC_BITS-1] ? '0 : acc_sum[FRAC_BITS +: COORD_BITS];
   assign major_next = major_down_ff ? major_pos_ff - 1'b1 : major_pos_ff + 1'b1;

   // The output register can take a pixel when empty or being drained.
   assign out_free = !out_valid_ff || rsp_tready;

   // Command sequencing and pixel emission.
   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      steep_in       = steep_ff;
      major_down_in  = major_down_ff;
      slope_neg_in   = slope_neg_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      minor_prev_in  = minor_prev_ff;
      minor_acc_in   = minor_acc_ff;
      minor_slope_in = minor_slope_ff;
      held_color_in  = held_color_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_color_in   = out_color_ff;
      out_done_in    = out_done_ff;
      out_last_in    = out_last_ff;
      pop            = 1'b0;
      div_start      = 1'b0;
      main_fire      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_cmd.mode == MODE_LOAD) begin
                  // A load replaces any line in progress.
                  pop            = 1'b1;
                  active_in      = 1'b1;
                  steep_in       = head_cmd.steep;
                  major_down_in  = head_cmd.major_down;
                  slope_neg_in   = head_cmd.minor_neg;
                  major_pos_in   = head_cmd.major_start;
                  major_end_in   = head_cmd.major_end;
                  minor_pos_in   = head_cmd.minor_start;
                  minor_prev_in  = head_cmd.minor_start;
                  minor_acc_in   = (signed'(ACC_BITS'(head_cmd.minor_start)) <<< FRAC_BITS)
                                   + signed'(ACC_BITS'(FRAC_SCALE / 2));
                  minor_slope_in = '0;
                  held_color_in  = head_cmd.color;
                  if (head_cmd.major_mag != '0) begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end else if (head_cmd.mode == MODE_STEP && !active_ff) begin
                  // A step with no line in progress is dropped.
                  pop = 1'b1;
               end else if (out_free) begin
                  pop          = 1'b1;
                  out_valid_in = 1'b1;
                  if (minor_pos_ff != minor_prev_ff) begin
                     // Staircase pixel at the previous minor position.
                     out_x_in      = steep_ff ? minor_prev_ff : major_pos_ff;
                     out_y_in      = steep_ff ? major_pos_ff : minor_prev_ff;
                     out_color_in  = held_color_ff;
                     out_done_in   = 1'b0;
                     out_last_in   = 1'b0;
                     minor_prev_in = minor_pos_ff;
                     state_in      = ST_MAIN;
                  end else begin
                     main_fire = 1'b1;
                  end
               end
            end
         end
         ST_MAIN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               main_fire    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               minor_slope_in = slope_neg_ff ? -slope_mag : slope_mag;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Main pixel of a step, then one move along the major axis, or the end of the line at its last pixel.
      if (main_fire) begin
         out_x_in     = steep_ff ? minor_pos_ff : major_pos_ff;
         out_y_in     = steep_ff ? major_pos_ff : minor_pos_ff;
         out_color_in = held_color_ff;
         out_done_in  = main_done;
         out_last_in  = 1'b1;
         if (main_done) begin
            active_in = 1'b0;
         end else begin
            minor_acc_in = acc_sum;
            minor_pos_in = acc_whole;
            major_pos_in = major_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_ff      <= 1'b0;
         steep_ff       <= 1'b0;
         major_down_ff  <= 1'b0;
         slope_neg_ff   <= 1'b0;
         major_pos_ff   <= '0;
         major_end_ff   <= '0;
         minor_pos_ff   <= '0;
         minor_prev_ff  <= '0;
         minor_acc_ff   <= '0;
         minor_slope_ff <= '0;
         held_color_ff  <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_ff      <= active_in;
         steep_ff       <= steep_in;
         major_down_ff  <= major_down_in;
         slope_neg_ff   <= slope_neg_in;
         major_pos_ff   <= major_pos_in;
         major_end_ff   <= major_end_in;
         minor_pos_ff   <= minor_pos_in;
         minor_prev_ff  <= minor_prev_in;
         minor_acc_ff   <= minor_acc_in;
         minor_slope_ff <= minor_slope_in;
         held_color_ff  <= held_color_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Output payload needs no reset.
   always_ff @(posedge clock) begin
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_done_ff  <= out_done_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid  = out_valid_ff;
   assign pixel_x     = out_x_ff;
   assign pixel_y     = out_y_ff;
   assign pixel_color = out_color_ff;
   assign line_done   = out_done_ff;
   assign pixel_last  = out_last_ff;

endmodule

>>> hw/rtl/dda_line_rasterizer_top.sv
// Top level of the fixed-point DDA line rasterizer with staircase fill.
//
//  Channel | Direction | Handshake             | Contents
//  req     | in        | req_tvalid/req_tready | tdata: start/end points, color; tuser: mode
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: pixel x, y, color; tuser: line done;
//          |           |                       | tlast: last pixel of the step
//
//  A load starts the bit-serial slope divider and the back end waits for its quotient;
//  a load of a point skips the divider.
//  A step emits one pixel, or two with a staircase pixel first, before the next command.
//  Reset is synchronous and clears the queue, the line state and the output valid flag.
//  The front end keeps accepting requests into the queue while the back end waits on
//  the divider or on rsp_tready; req_tready falls only when the queue is full.
module dda_line_rasterizer_top
   import ddar_pkg::*;
#(
   parameter int  COORD_BITS    = COORD_BITS_DEF,
   parameter int  QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   localparam int REQ_DATA_BITS = ((4*COORD_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((2*COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // start_x, start_y, end_x, end_y, line_color (lowest bits first), zero filled
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // mode
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // pixel_x, pixel_y, pixel_color (lowest bits first), zero filled
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // line_done
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   typedef struct packed {
      logic                  mode;
      logic                  steep;
      logic                  major_down;
      logic                  minor_neg;
      logic [COORD_BITS-1:0] major_start;
      logic [COORD_BITS-1:0] major_end;
      logic [COORD_BITS-1:0] minor_start;
      logic [COORD_BITS-1:0] minor_mag;
      logic [COORD_BITS-1:0] major_mag;
      logic [COLOR_BITS-1:0] color;
   } cmd_type;

   logic                  push_valid;
   cmd_type               push_cmd;
   logic                  queue_full;
   logic                  pop;
   logic                  head_valid;
   cmd_type               head_cmd;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [COLOR_BITS-1:0] pixel_color;

   ddar_front #(
      .COORD_BITS (COORD_BITS),
      .cmd_type   (cmd_type)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   ddar_queue #(
      .DEPTH    (QUEUE_DEPTH),
      .cmd_type (cmd_type)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ddar_back #(
      .COORD_BITS (COORD_BITS),
      .cmd_type   (cmd_type)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .pixel_color (pixel_color),
      .line_done   (rsp_tuser),
      .pixel_last  (rsp_tlast)
   );

   // Pack the pixel into the result bus, zero filled to whole bytes.
   assign rsp_tdata = RSP_DATA_BITS'({pixel_color, pixel_y, pixel_x});

endmodule

>>> dv/tb.sv
// Self-checking testbench for the DDA line rasterizer: directed table, random lines, pixel checks.
`timescale 1ns / 100ps

module tb;
   import ddar_pkg::*;

   localparam int CB            = COORD_BITS_DEF;
   localparam int REQ_W         = ((4*CB + COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_W         = ((2*CB + COLOR_BITS + 7) / 8) * 8;
   localparam int CMAX          = (1 << CB) - 1;
   localparam int ITEM_TARGET   = 800;
   localparam int QUIET_FROM    = 700;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 2 * (CB + 14);
   localparam int MAX_REPORTS   = 10;
   localparam int SCRIPT_ROWS   = 23;
   localparam bit TYPED         = 1'b1;
   localparam bit PREDICTED     = 1'b0;

   // One pixel as it leaves the block.
   typedef struct packed {
      logic [CB-1:0]         x;
      logic [CB-1:0]         y;
      logic [COLOR_BITS-1:0] color;
      logic                  done;
      logic                  last;
   } pixel_type;

   // One row of the directed script; typed rows carry their own expectation.
   typedef struct packed {
      logic                  mode;
      logic [CB-1:0]         sx;
      logic [CB-1:0]         sy;
      logic [CB-1:0]         ex;
      logic [CB-1:0]         ey;
      logic [COLOR_BITS-1:0] color;
      logic                  typed;
      logic                  has_pix;
      pixel_type             pix;
   } script_row_type;

   localparam pixel_type NO_PIX = '0;

   // Directed script: idle steps, single-point lines at both corners, a short
   // horizontal line, a 45-degree line (equal deltas go steep), a shallow line
   // running backwards with a falling minor axis, and a load that replaces a
   // line still in progress.
   script_row_type directed_script [0:SCRIPT_ROWS-1] = '{
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, TYPED,     1'b0, NO_PIX},
      '{MODE_LOAD, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, TYPED,     1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, TYPED,     1'b1,
        '{12'd0, 12'd0, 24'h000000, 1'b1, 1'b1}},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, TYPED,     1'b0, NO_PIX},
      '{MODE_LOAD, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 24'hFFFFFF, TYPED,     1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, TYPED,     1'b1,
        '{12'd4095, 12'd4095, 24'hFFFFFF, 1'b1, 1'b1}},
      '{MODE_LOAD, 12'd4094, 12'd5,    12'd4095, 12'd5,    24'hA5A5A5, TYPED,     1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_LOAD, 12'd0,    12'd0,    12'd3,    12'd3,    24'h5A5A5A, TYPED,     1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_LOAD, 12'd4095, 12'd4095, 12'd4090, 12'd4093, 24'h123456, TYPED,     1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_LOAD, 12'd0,    12'd4095, 12'd3,    12'd4088, 24'hFEDCBA, TYPED,     1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX},
      '{MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    24'h000000, PREDICTED, 1'b0, NO_PIX}
   };

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tuser  = MODE_LOAD;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;

   // Line state of the predictor.
   bit                    ln_active;
   bit                    ln_steep;
   bit                    ln_major_down;
   bit [CB-1:0]           ln_major_pos;
   bit [CB-1:0]           ln_major_end;
   bit [CB-1:0]           ln_minor_pos;
   bit [CB-1:0]           ln_minor_prev;
   longint                ln_acc;
   longint                ln_slope;
   bit [COLOR_BITS-1:0]   ln_color;

   pixel_type   step_pix [2];
   int          step_cnt;
   pixel_type   pending_pixels [$];

   bit       idle_on;
   int       stall_left;
   int       mismatches;
   int       cycle_cnt;
   int       items;
   int       n_loads;
   int       n_steps;
   int       n_stairs;
   int       n_pixels;
   int       n_done;

   dda_line_rasterizer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Map a major/minor position pair onto screen coordinates.
   function automatic pixel_type make_pixel(input logic [CB-1:0] maj, input logic [CB-1:0] mnr,
                                            input logic done, input logic is_last);
      pixel_type p;
      p.x     = ln_steep ? mnr : maj;
      p.y     = ln_steep ? maj : mnr;
      p.color = ln_color;
      p.done  = done;
      p.last  = is_last;
      return p;
   endfunction

   // Advance the line state by one request and collect the pixels it emits.
   task automatic rasterize_request(input logic mode, input int sx, input int sy,
                                    input int ex, input int ey,
                                    input logic [COLOR_BITS-1:0] color);
      int     dx, dy, adx, ady, smaj, emaj, smin, dmin, amaj;
      longint mag, quo;
      logic   done;
      step_cnt = 0;
      if (mode == MODE_LOAD) begin
         dx  = ex - sx;
         dy  = ey - sy;
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         ln_steep = !(adx > ady);
         if (ln_steep) begin
            smaj = sy; emaj = ey; smin = sx; dmin = dx; amaj = ady;
         end else begin
            smaj = sx; emaj = ex; smin = sy; dmin = dy; amaj = adx;
         end
         // Slope magnitude is truncated before the sign goes back on.
         if (amaj == 0) begin
            ln_slope = 0;
         end else begin
            mag      = longint'(dmin < 0 ? -dmin : dmin) * FRAC_SCALE / amaj;
            ln_slope = dmin < 0 ? -mag : mag;
         end
         ln_major_pos  = smaj[CB-1:0];
         ln_major_end  = emaj[CB-1:0];
         ln_major_down = emaj < smaj;
         ln_minor_pos  = smin[CB-1:0];
         ln_minor_prev = smin[CB-1:0];
         ln_acc        = longint'(smin) * FRAC_SCALE + FRAC_SCALE / 2;
         ln_color      = color;
         ln_active     = 1'b1;
      end else if (ln_active) begin
         done = (ln_major_pos == ln_major_end);
         // A change of minor position fills the corner of the staircase first.
         if (ln_minor_pos != ln_minor_prev) begin
            step_pix[step_cnt] = make_pixel(ln_major_pos, ln_minor_prev, 1'b0, 1'b0);
            step_cnt++;
            ln_minor_prev = ln_minor_pos;
         end
         step_pix[step_cnt] = make_pixel(ln_major_pos, ln_minor_pos, done, 1'b1);
         step_cnt++;
         if (done) begin
            ln_active = 1'b0;
         end else begin
            ln_acc       = ln_acc + ln_slope;
            quo          = ln_acc < 0 ? 0 : ln_acc / FRAC_SCALE;
            ln_minor_pos = quo[CB-1:0];
            ln_major_pos = ln_major_down ? ln_major_pos - 1'b1 : ln_major_pos + 1'b1;
         end
      end
   endtask

   // Offer one request, wait for it to be taken, then record what it should produce.
   task automatic send_request(input logic mode, input logic [REQ_W-1:0] data,
                               input bit use_typed, input bit typed_has,
                               input pixel_type typed_pix);
      bit counts;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);

      counts = (mode == MODE_LOAD) || ln_active;
      rasterize_request(mode, data[0 +: CB], data[CB +: CB], data[2*CB +: CB],
                        data[3*CB +: CB], data[4*CB +: COLOR_BITS]);
      if (use_typed) begin
         if (typed_has) pending_pixels.push_back(typed_pix);
      end else begin
         for (int i = 0; i < step_cnt; i++) pending_pixels.push_back(step_pix[i]);
      end
      if (counts) items++;
      if (mode == MODE_LOAD) n_loads++;
      else n_steps++;
      if (step_cnt == 2) n_stairs++;
   endtask

   task automatic send_load(input int sx, input int sy, input int ex, input int ey,
                            input logic [COLOR_BITS-1:0] color);
      logic [REQ_W-1:0] data;
      data = REQ_W'({color, ey[CB-1:0], ex[CB-1:0], sy[CB-1:0], sx[CB-1:0]});
      send_request(MODE_LOAD, data, PREDICTED, 1'b0, NO_PIX);
   endtask

   // Step requests carry random payload bits, which the block ignores.
   task automatic send_step();
      logic [REQ_W-1:0] data;
      data = REQ_W'({$urandom, $urandom, $urandom});
      send_request(MODE_STEP, data, PREDICTED, 1'b0, NO_PIX);
   endtask

   // Hold the request side until every expected pixel has come out.
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Pixel checker and receiver stall pattern.
   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x     = rsp_tdata[0 +: CB];
         got.y     = rsp_tdata[CB +: CB];
         got.color = rsp_tdata[2*CB +: COLOR_BITS];
         got.done  = rsp_tuser;
         got.last  = rsp_tlast;
         n_pixels++;
         if (got.done) n_done++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected pixel x=%0d y=%0d color=%06h done=%0b last=%0b",
                        $realtime, got.x, got.y, got.color, got.done, got.last);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"%0t: pixel mismatch, expected x=%0d y=%0d color=%06h done=%0b ",
                            "last=%0b, got x=%0d y=%0d color=%06h done=%0b last=%0b"},
                           $realtime, want.x, want.y, want.color, want.done, want.last,
                           got.x, got.y, got.color, got.done, got.last);
            end
         end
      end

      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 3) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels still expected",
                  cycle_cnt, pending_pixels.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Main sequence: reset, directed script, random lines, drain.
   initial begin
      int sx, sy, ex, ey, dx, dy, len, n_line_steps, kind, line_no;
      idle_on = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         send_request(directed_script[r].mode,
                      REQ_W'({directed_script[r].color, directed_script[r].ey,
                              directed_script[r].ex, directed_script[r].sy,
                              directed_script[r].sx}),
                      directed_script[r].typed, directed_script[r].has_pix,
                      directed_script[r].pix);
      end
      drain_pixels();

      line_no = 0;
      while (items < ITEM_TARGET) begin
         // Idling comes and goes per line and stops for the closing stretch.
         idle_on = (items < QUIET_FROM) && ($urandom_range(0, 7) != 0);
         if (line_no % 10 == 9) drain_pixels();
         kind = $urandom_range(0, 99);

         // A stray step, landing mid-line or on an idle block.
         if (kind < 5) send_step();

         if (kind < 12) begin
            // Far endpoints: only the first few pixels, then the next load cuts in.
            sx = $urandom_range(0, CMAX);
            sy = $urandom_range(0, CMAX);
            ex = $urandom_range(0, CMAX);
            ey = $urandom_range(0, CMAX);
            n_line_steps = $urandom_range(0, 8);
         end else begin
            sx = $urandom_range(0, CMAX);
            sy = $urandom_range(0, CMAX);
            if (kind < 17) begin
               dx = 0;
               dy = 0;
            end else begin
               dx = $urandom_range(0, 20);
               dy = $urandom_range(0, 20);
               if ($urandom_range(0, 1)) dx = -dx;
               if ($urandom_range(0, 1)) dy = -dy;
            end
            ex = sx + dx;
            ey = sy + dy;
            if (ex < 0) ex = 0;
            if (ex > CMAX) ex = CMAX;
            if (ey < 0) ey = 0;
            if (ey > CMAX) ey = CMAX;
            dx  = ex - sx;
            dy  = ey - sy;
            len = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                            : (dy < 0 ? -dy : dy);
            n_line_steps = len + 1;
            if (kind >= 90) n_line_steps += $urandom_range(1, 2);
            else if (kind >= 82) n_line_steps = $urandom_range(0, len);
         end

         send_load(sx, sy, ex, ey, $urandom & 24'hFFFFFF);
         repeat (n_line_steps) send_step();
         line_no++;
      end

      idle_on = 1'b0;
      drain_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads and %0d steps over %0d random lines", n_loads, n_steps, line_no);
      $display("checked %0d pixels, %0d staircase fills, %0d line ends, %0d mismatches",
               n_pixels, n_stairs, n_done, mismatches);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> dda_line_rasterizer_top.f
hw/rtl/ddar_pkg.sv
hw/rtl/ddar_front.sv
hw/rtl/ddar_queue.sv
hw/rtl/ddar_div.sv
hw/rtl/ddar_back.sv
hw/rtl/dda_line_rasterizer_top.sv
dv/tb.sv
